// File: rtl/crt_pkg.sv
// crt_pkg: shared widths, types and codes for the cable ribbon tessellator.
// No dependencies; imported by crt_front, crt_back and the top level.
`default_nettype none

package crt_pkg;

  // parameter defaults
  localparam int DEF_MAX_SEGMENTS = 31;
  localparam int DEF_COORD_BITS   = 32;

  // field widths
  localparam int COORD_W   = 32;
  localparam int WIDTH_W   = 31;
  localparam int SEG_W     = 5;
  localparam int IDX_W     = 6;
  localparam int CFG_IDX_W = 2;

  // internal datapath widths
  localparam int MID_W   = 33;  // control point, floor half sum, minus sag on y
  localparam int PT_W    = 34;  // curve point
  localparam int VEC_W   = 36;  // vector before normalizing
  localparam int UNIT_W  = 18;  // signed Q1.16 unit component, |u| <= 1.0
  localparam int MA_W    = 34;  // multiplier operand a
  localparam int MB_W    = 32;  // multiplier operand b
  localparam int PROD_W  = 64;
  localparam int COEF_W  = 10;  // Bernstein weights, up to 31^2
  localparam int DIV_NW  = 48;
  localparam int DIV_DW  = 32;
  localparam int SQ_W    = 62;
  localparam int LEN_W   = 31;
  localparam int SAT_W   = 50;

  // queue depths
  localparam int DESC_DEPTH = 2;
  localparam int OUT_DEPTH  = 2;

  // config register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_CAMERA_X = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_CAMERA_Y = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_CAMERA_Z = 2'd2;

  typedef logic signed [COORD_W-1:0] coord_t;
  typedef logic signed [MID_W-1:0]   mid_t;
  typedef logic signed [PT_W-1:0]    pt_t;
  typedef logic signed [VEC_W-1:0]   vec_t;
  typedef logic signed [UNIT_W-1:0]  unit_t;
  typedef logic signed [PROD_W-1:0]  prod_t;

  // one cable after the front end
  typedef struct packed {
    coord_t [2:0]       s;
    mid_t   [2:0]       m;
    coord_t [2:0]       e;
    logic [WIDTH_W-1:0] width;
    logic [SEG_W-1:0]   n;
  } desc_t;

  // one strip vertex
  typedef struct packed {
    coord_t             x;
    coord_t             y;
    coord_t             z;
    logic [IDX_W-1:0]   index;
    logic               degenerate;
    logic               last;
  } vert_t;

endpackage

`default_nettype wire

// File: rtl/crt_fifo.sv
// crt_fifo: small register queue of fixed width beats.
// Standalone; used between front and back and at the result side.
`default_nettype none

module crt_fifo #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 2
) (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             wr_en,
  input  wire logic [WIDTH-1:0] wr_data,
  output logic                  full,
  input  wire logic             rd_en,
  output logic [WIDTH-1:0]      rd_data,
  output logic                  empty
);

  localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [PW-1:0]    wr_ptr;
  logic [PW-1:0]    rd_ptr;
  logic [CW-1:0]    count;
  logic             do_wr;
  logic             do_rd;

  assign full    = (count == CW'(DEPTH));
  assign empty   = (count == '0);
  assign do_wr   = wr_en && !full;
  assign do_rd   = rd_en && !empty;
  assign rd_data = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (do_wr) begin
      mem[wr_ptr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_wr) begin
        wr_ptr <= (wr_ptr == PW'(DEPTH - 1)) ? '0 : wr_ptr + PW'(1);
      end
      if (do_rd) begin
        rd_ptr <= (rd_ptr == PW'(DEPTH - 1)) ? '0 : rd_ptr + PW'(1);
      end
      if (do_wr && !do_rd) begin
        count <= count + CW'(1);
      end else if (do_rd && !do_wr) begin
        count <= count - CW'(1);
      end
    end
  end

endmodule

`default_nettype wire

// File: rtl/crt_front.sv
// crt_front: accepts cable beats, drops inactive cables, forms the control
// point and the clamped segment count. Depends on crt_pkg.
`default_nettype none

module crt_front #(
  parameter int MAX_SEGMENTS = crt_pkg::DEF_MAX_SEGMENTS
) (
  input  wire logic                        push,
  output logic                             full,
  input  wire crt_pkg::coord_t             start_x,
  input  wire crt_pkg::coord_t             start_y,
  input  wire crt_pkg::coord_t             start_z,
  input  wire crt_pkg::coord_t             end_x,
  input  wire crt_pkg::coord_t             end_y,
  input  wire crt_pkg::coord_t             end_z,
  input  wire crt_pkg::coord_t             sag,
  input  wire logic [crt_pkg::WIDTH_W-1:0] ribbon_width,
  input  wire logic [crt_pkg::SEG_W-1:0]   segment_count,
  input  wire logic                        cable_active,
  input  wire logic                        q_full,
  output logic                             q_push,
  output crt_pkg::desc_t                   q_desc
);
  import crt_pkg::*;

  logic signed [COORD_W:0] sum [3];
  mid_t                    half [3];
  coord_t                  sp [3];
  coord_t                  ep [3];

  assign sp[0] = start_x;
  assign sp[1] = start_y;
  assign sp[2] = start_z;
  assign ep[0] = end_x;
  assign ep[1] = end_y;
  assign ep[2] = end_z;

  always_comb begin
    for (int k = 0; k < 3; k++) begin
      sum[k]  = (COORD_W + 1)'(sp[k]) + (COORD_W + 1)'(ep[k]);
      half[k] = MID_W'(sum[k] >>> 1);
    end
  end

  always_comb begin
    q_desc.s[0]  = start_x;
    q_desc.s[1]  = start_y;
    q_desc.s[2]  = start_z;
    q_desc.e[0]  = end_x;
    q_desc.e[1]  = end_y;
    q_desc.e[2]  = end_z;
    q_desc.m[0]  = half[0];
    q_desc.m[1]  = half[1] - MID_W'(sag);
    q_desc.m[2]  = half[2];
    q_desc.width = ribbon_width;
    if (segment_count == '0) begin
      q_desc.n = SEG_W'(1);
    end else if (segment_count > SEG_W'(MAX_SEGMENTS)) begin
      q_desc.n = SEG_W'(MAX_SEGMENTS);
    end else begin
      q_desc.n = segment_count;
    end
  end

  // inactive cables are taken and dropped
  assign full   = q_full;
  assign q_push = push && !q_full && cable_active;

endmodule

`default_nettype wire

// File: rtl/crt_div.sv
// crt_div: restoring unsigned divider, one quotient bit per cycle.
// Standalone; shared by curve evaluation and normalization in crt_back.
`default_nettype none

module crt_div #(
  parameter int NW = 48,
  parameter int DW = 32
) (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire logic          start,
  input  wire logic [NW-1:0] num,
  input  wire logic [DW-1:0] den,
  output logic               done,
  output logic [NW-1:0]      quot
);

  localparam int CW = $clog2(NW + 1);

  logic [NW-1:0] q;
  logic [DW:0]   rem;
  logic [DW-1:0] dv;
  logic [CW-1:0] cnt;
  logic          busy;
  logic [DW:0]   remsh;
  logic          ge;

  assign remsh = {rem[DW-1:0], q[NW-1]};
  assign ge    = remsh >= {1'b0, dv};
  assign quot  = q;

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        q    <= num;
        dv   <= den;
        rem  <= '0;
        cnt  <= CW'(NW);
        busy <= 1'b1;
      end else if (busy) begin
        q   <= {q[NW-2:0], ge};
        rem <= ge ? remsh - {1'b0, dv} : remsh;
        cnt <= cnt - CW'(1);
        if (cnt == CW'(1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

endmodule

`default_nettype wire

// File: rtl/crt_back.sv
// crt_back: per cable sequencer. Curve points, three normalizations, cross
// product, side offset and vertex emission on one multiplier and crt_div.
// Depends on crt_pkg, crt_div.
`default_nettype none

module crt_back #(
  parameter int COORD_BITS = crt_pkg::DEF_COORD_BITS
) (
  input  wire logic                     clk,
  input  wire logic                     rst,
  input  wire crt_pkg::desc_t           desc,
  input  wire logic                     desc_empty,
  output logic                          desc_pop,
  input  wire crt_pkg::coord_t [2:0]    cam,
  output crt_pkg::vert_t                out_vert,
  output logic                          out_push,
  input  wire logic                     out_full
);
  import crt_pkg::*;

  localparam logic [4:0] ST_IDLE    = 5'd0;
  localparam logic [4:0] ST_START   = 5'd1;
  localparam logic [4:0] ST_CP_COEF = 5'd2;
  localparam logic [4:0] ST_CP_MUL  = 5'd3;
  localparam logic [4:0] ST_CP_DIV  = 5'd4;
  localparam logic [4:0] ST_CP_WAIT = 5'd5;
  localparam logic [4:0] ST_DIR     = 5'd6;
  localparam logic [4:0] ST_U_ABS   = 5'd7;
  localparam logic [4:0] ST_U_NORM  = 5'd8;
  localparam logic [4:0] ST_U_SQ    = 5'd9;
  localparam logic [4:0] ST_U_SQRT  = 5'd10;
  localparam logic [4:0] ST_U_DIV   = 5'd11;
  localparam logic [4:0] ST_U_WAIT  = 5'd12;
  localparam logic [4:0] ST_U_DONE  = 5'd13;
  localparam logic [4:0] ST_CROSS   = 5'd14;
  localparam logic [4:0] ST_SIDE    = 5'd15;
  localparam logic [4:0] ST_EMIT_L  = 5'd16;
  localparam logic [4:0] ST_EMIT_R  = 5'd17;

  localparam logic [1:0] UJ_DIR   = 2'd0;
  localparam logic [1:0] UJ_VIEW  = 2'd1;
  localparam logic [1:0] UJ_CROSS = 2'd2;

  localparam logic [VEC_W-1:0] NORM_HI = VEC_W'(1) << 30;
  localparam logic [VEC_W-1:0] NORM_LO = VEC_W'(1) << 29;
  localparam logic [SQ_W-1:0]  SQ_TOP  = SQ_W'(1) << 60;

  localparam logic signed [SAT_W-1:0] LIM_HI =
    (SAT_W'(1) <<< (COORD_BITS - 1)) - SAT_W'(1);
  localparam logic signed [SAT_W-1:0] LIM_LO = -LIM_HI - SAT_W'(1);

  logic [4:0]          state;
  desc_t               dsc;
  logic [SEG_W-1:0]    smp;
  logic [SEG_W-1:0]    jdx;
  logic                cp_dst;
  logic                cp_neg;
  logic [1:0]          axis;
  logic [2:0]          step;
  logic [1:0]          ujob;
  logic                ok;
  logic [COEF_W-1:0]   coef_a;
  logic [COEF_W-1:0]   coef_b;
  logic [COEF_W-1:0]   coef_c;
  logic [COEF_W-1:0]   dsq;
  pt_t [2:0]           cur;
  pt_t [2:0]           nxt;
  pt_t [2:0]           prv;
  vec_t [2:0]          vec;
  logic [2:0][VEC_W-1:0] mag;
  logic [2:0]          neg;
  logic [VEC_W-1:0]    mx;
  logic [SQ_W-1:0]     sq_v;
  logic [SQ_W-1:0]     sq_res;
  logic [SQ_W-1:0]     sq_bit;
  logic [LEN_W-1:0]    len;
  unit_t [2:0]         ud;
  unit_t [2:0]         uv;
  unit_t [2:0]         uc;
  coord_t [2:0]        side;
  prod_t               prod;
  prod_t               acc;

  logic signed [MA_W-1:0]      mul_a;
  logic signed [MB_W-1:0]      mul_b;
  logic signed [MA_W+MB_W-1:0] mul_full;

  logic              div_start;
  logic [DIV_NW-1:0] div_num;
  logic [DIV_DW-1:0] div_den;
  logic              div_done;
  logic [DIV_NW-1:0] div_quot;

  logic [2:0][VEC_W-1:0] abs_v;
  logic [VEC_W-1:0]      abs_mx;
  prod_t                 cp_num;
  prod_t                 cp_abs;
  pt_t                   cp_q;
  pt_t                   cp_val;
  unit_t                 u_q;
  unit_t                 u_val;
  coord_t                side_f;
  logic [SQ_W-1:0]       sq_try;
  logic [SEG_W-1:0]      nj;

  crt_div #(.NW(DIV_NW), .DW(DIV_DW)) u_div (
    .clk   (clk),
    .rst   (rst),
    .start (div_start),
    .num   (div_num),
    .den   (div_den),
    .done  (div_done),
    .quot  (div_quot)
  );

  function automatic coord_t sat_out(input logic signed [SAT_W-1:0] v);
    logic signed [SAT_W-1:0] r;
    r = v;
    if (v > LIM_HI) begin
      r = LIM_HI;
    end else if (v < LIM_LO) begin
      r = LIM_LO;
    end
    return r[COORD_W-1:0];
  endfunction

  // ---- shared multiplier, product registered ----
  always_comb begin
    mul_a = '0;
    mul_b = '0;
    case (state)
      ST_CP_MUL: begin
        case (step)
          3'd0: begin
            mul_a = MA_W'(dsc.s[axis]);
            mul_b = MB_W'(coef_a);
          end
          3'd1: begin
            mul_a = MA_W'(dsc.m[axis]);
            mul_b = MB_W'(coef_b);
          end
          3'd2: begin
            mul_a = MA_W'(dsc.e[axis]);
            mul_b = MB_W'(coef_c);
          end
          default: ;
        endcase
      end
      ST_U_SQ: begin
        case (step)
          3'd0: begin
            mul_a = MA_W'(mag[0][29:0]);
            mul_b = MB_W'(mag[0][29:0]);
          end
          3'd1: begin
            mul_a = MA_W'(mag[1][29:0]);
            mul_b = MB_W'(mag[1][29:0]);
          end
          3'd2: begin
            mul_a = MA_W'(mag[2][29:0]);
            mul_b = MB_W'(mag[2][29:0]);
          end
          default: ;
        endcase
      end
      ST_CROSS: begin
        case (step)
          3'd0: begin
            mul_a = MA_W'(ud[1]);
            mul_b = MB_W'(uv[2]);
          end
          3'd1: begin
            mul_a = MA_W'(ud[2]);
            mul_b = MB_W'(uv[1]);
          end
          3'd2: begin
            mul_a = MA_W'(ud[2]);
            mul_b = MB_W'(uv[0]);
          end
          3'd3: begin
            mul_a = MA_W'(ud[0]);
            mul_b = MB_W'(uv[2]);
          end
          3'd4: begin
            mul_a = MA_W'(ud[0]);
            mul_b = MB_W'(uv[1]);
          end
          3'd5: begin
            mul_a = MA_W'(ud[1]);
            mul_b = MB_W'(uv[0]);
          end
          default: ;
        endcase
      end
      ST_SIDE: begin
        case (step)
          3'd0: mul_a = MA_W'(uc[0]);
          3'd1: mul_a = MA_W'(uc[1]);
          3'd2: mul_a = MA_W'(uc[2]);
          default: ;
        endcase
        mul_b = MB_W'(dsc.width);
      end
      default: ;
    endcase
  end

  assign mul_full = mul_a * mul_b;

  always_ff @(posedge clk) begin
    prod <= mul_full[PROD_W-1:0];
  end

  // ---- helpers ----
  always_comb begin
    for (int k = 0; k < 3; k++) begin
      abs_v[k] = vec[k][VEC_W-1] ? VEC_W'(-vec[k]) : VEC_W'(vec[k]);
    end
    abs_mx = abs_v[0];
    if (abs_v[1] > abs_mx) begin
      abs_mx = abs_v[1];
    end
    if (abs_v[2] > abs_mx) begin
      abs_mx = abs_v[2];
    end
  end

  assign nj     = dsc.n - jdx;
  assign cp_num = acc + prod_t'(dsq >> 1);
  assign cp_abs = cp_num[PROD_W-1] ? (-cp_num + prod_t'(dsq) - prod_t'(1)) : cp_num;
  assign cp_q   = pt_t'(div_quot[PT_W-1:0]);
  assign cp_val = cp_neg ? -cp_q : cp_q;
  assign u_q    = unit_t'(div_quot[UNIT_W-1:0]);
  assign u_val  = neg[axis] ? -u_q : u_q;
  assign side_f = coord_t'((prod + prod_t'(65536)) >>> 17);
  assign sq_try = sq_res + sq_bit;

  // ---- emission ----
  assign desc_pop = (state == ST_IDLE) && !desc_empty;
  assign out_push = ((state == ST_EMIT_L) || (state == ST_EMIT_R)) && !out_full;

  always_comb begin
    if (state == ST_EMIT_R) begin
      out_vert.x = sat_out(SAT_W'(cur[0]) + SAT_W'(side[0]));
      out_vert.y = sat_out(SAT_W'(cur[1]) + SAT_W'(side[1]));
      out_vert.z = sat_out(SAT_W'(cur[2]) + SAT_W'(side[2]));
    end else begin
      out_vert.x = sat_out(SAT_W'(cur[0]) - SAT_W'(side[0]));
      out_vert.y = sat_out(SAT_W'(cur[1]) - SAT_W'(side[1]));
      out_vert.z = sat_out(SAT_W'(cur[2]) - SAT_W'(side[2]));
    end
    out_vert.index      = {smp, state == ST_EMIT_R};
    out_vert.degenerate = !ok;
    out_vert.last       = (state == ST_EMIT_R) && (smp == dsc.n);
  end

  // ---- sequencer ----
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      div_start <= 1'b0;
    end else begin
      div_start <= 1'b0;
      case (state)
        ST_IDLE: begin
          if (!desc_empty) begin
            dsc   <= desc;
            smp   <= '0;
            state <= ST_START;
          end
        end

        // P(i) comes from the previous look-ahead; only P(i+1) is new (i = 0 makes both, i = n none)
        ST_START: begin
          if (smp == '0) begin
            jdx    <= '0;
            cp_dst <= 1'b0;
            state  <= ST_CP_COEF;
          end else begin
            prv <= cur;
            cur <= nxt;
            if (smp < dsc.n) begin
              jdx    <= smp + SEG_W'(1);
              cp_dst <= 1'b1;
              state  <= ST_CP_COEF;
            end else begin
              state <= ST_DIR;
            end
          end
        end

        ST_CP_COEF: begin
          coef_a <= COEF_W'(nj) * COEF_W'(nj);
          coef_b <= (COEF_W'(jdx) * COEF_W'(nj)) << 1;
          coef_c <= COEF_W'(jdx) * COEF_W'(jdx);
          dsq    <= COEF_W'(dsc.n) * COEF_W'(dsc.n);
          axis   <= '0;
          step   <= '0;
          state  <= ST_CP_MUL;
        end

        ST_CP_MUL: begin
          if (step != '0) begin
            acc <= ((step == 3'd1) ? prod_t'(0) : acc) + prod;
          end
          if (step == 3'd3) begin
            state <= ST_CP_DIV;
          end else begin
            step <= step + 3'd1;
          end
        end

        // floor division: negative numerators divide n^2-1 biased magnitude
        ST_CP_DIV: begin
          cp_neg    <= cp_num[PROD_W-1];
          div_num   <= cp_abs[DIV_NW-1:0];
          div_den   <= DIV_DW'(dsq);
          div_start <= 1'b1;
          state     <= ST_CP_WAIT;
        end

        ST_CP_WAIT: begin
          if (div_done) begin
            if (cp_dst) begin
              nxt[axis] <= cp_val;
            end else begin
              cur[axis] <= cp_val;
            end
            if (axis == 2'd2) begin
              if (!cp_dst) begin
                jdx    <= SEG_W'(1);
                cp_dst <= 1'b1;
                state  <= ST_CP_COEF;
              end else begin
                state <= ST_DIR;
              end
            end else begin
              axis  <= axis + 2'd1;
              step  <= '0;
              state <= ST_CP_MUL;
            end
          end
        end

        ST_DIR: begin
          for (int k = 0; k < 3; k++) begin
            if (smp < dsc.n) begin
              vec[k] <= VEC_W'(nxt[k]) - VEC_W'(cur[k]);
            end else begin
              vec[k] <= VEC_W'(cur[k]) - VEC_W'(prv[k]);
            end
          end
          ok    <= 1'b1;
          ujob  <= UJ_DIR;
          state <= ST_U_ABS;
        end

        ST_U_ABS: begin
          for (int k = 0; k < 3; k++) begin
            mag[k] <= abs_v[k];
            neg[k] <= vec[k][VEC_W-1];
          end
          mx <= abs_mx;
          if (abs_mx == '0) begin
            ok <= 1'b0;
            case (ujob)
              UJ_DIR:  ud <= '0;
              UJ_VIEW: uv <= '0;
              default: uc <= '0;
            endcase
            state <= ST_U_DONE;
          end else begin
            state <= ST_U_NORM;
          end
        end

        // one binary step a cycle until the peak lies in [2^29, 2^30)
        ST_U_NORM: begin
          if (mx >= NORM_HI) begin
            for (int k = 0; k < 3; k++) begin
              mag[k] <= mag[k] >> 1;
            end
            mx <= mx >> 1;
          end else if (mx < NORM_LO) begin
            for (int k = 0; k < 3; k++) begin
              mag[k] <= mag[k] << 1;
            end
            mx <= mx << 1;
          end else begin
            step  <= '0;
            state <= ST_U_SQ;
          end
        end

        ST_U_SQ: begin
          if (step != '0) begin
            acc <= ((step == 3'd1) ? prod_t'(0) : acc) + prod;
          end
          if (step == 3'd3) begin
            sq_v   <= SQ_W'(acc + prod);
            sq_res <= '0;
            sq_bit <= SQ_TOP;
            state  <= ST_U_SQRT;
          end else begin
            step <= step + 3'd1;
          end
        end

        // digit-by-digit square root, two radicand bits a cycle
        ST_U_SQRT: begin
          if (sq_bit == '0) begin
            len   <= sq_res[LEN_W-1:0];
            axis  <= '0;
            state <= ST_U_DIV;
          end else begin
            if (sq_v >= sq_try) begin
              sq_v   <= sq_v - sq_try;
              sq_res <= (sq_res >> 1) + sq_bit;
            end else begin
              sq_res <= sq_res >> 1;
            end
            sq_bit <= sq_bit >> 2;
          end
        end

        ST_U_DIV: begin
          div_num   <= DIV_NW'({mag[axis][29:0], 16'd0}) + DIV_NW'(len >> 1);
          div_den   <= DIV_DW'(len);
          div_start <= 1'b1;
          state     <= ST_U_WAIT;
        end

        ST_U_WAIT: begin
          if (div_done) begin
            case (ujob)
              UJ_DIR:  ud[axis] <= u_val;
              UJ_VIEW: uv[axis] <= u_val;
              default: uc[axis] <= u_val;
            endcase
            if (axis == 2'd2) begin
              state <= ST_U_DONE;
            end else begin
              axis  <= axis + 2'd1;
              state <= ST_U_DIV;
            end
          end
        end

        ST_U_DONE: begin
          case (ujob)
            UJ_DIR: begin
              for (int k = 0; k < 3; k++) begin
                vec[k] <= VEC_W'(cam[k]) - VEC_W'(cur[k]);
              end
              ujob  <= UJ_VIEW;
              state <= ST_U_ABS;
            end
            UJ_VIEW: begin
              step  <= '0;
              state <= ST_CROSS;
            end
            default: begin
              step  <= '0;
              state <= ST_SIDE;
            end
          endcase
        end

        ST_CROSS: begin
          case (step)
            3'd1: acc <= prod;
            3'd2: vec[0] <= VEC_W'(acc - prod);
            3'd3: acc <= prod;
            3'd4: vec[1] <= VEC_W'(acc - prod);
            3'd5: acc <= prod;
            3'd6: vec[2] <= VEC_W'(acc - prod);
            default: ;
          endcase
          if (step == 3'd6) begin
            ujob  <= UJ_CROSS;
            state <= ST_U_ABS;
          end else begin
            step <= step + 3'd1;
          end
        end

        ST_SIDE: begin
          case (step)
            3'd1: side[0] <= side_f;
            3'd2: side[1] <= side_f;
            3'd3: side[2] <= side_f;
            default: ;
          endcase
          if (step == 3'd3) begin
            state <= ST_EMIT_L;
          end else begin
            step <= step + 3'd1;
          end
        end

        ST_EMIT_L: begin
          if (!out_full) begin
            state <= ST_EMIT_R;
          end
        end

        ST_EMIT_R: begin
          if (!out_full) begin
            if (smp == dsc.n) begin
              state <= ST_IDLE;
            end else begin
              smp   <= smp + SEG_W'(1);
              state <= ST_START;
            end
          end
        end

        default: state <= ST_IDLE;
      endcase
    end
  end

endmodule

`default_nettype wire

// File: rtl/cable_ribbon_tessellator.sv
// cable_ribbon_tessellator: top level. Camera registers, cable front end,
// cable queue, tessellation back end and vertex queue.
// Depends on crt_pkg, crt_fifo, crt_front, crt_back (and crt_div below it).
//
//  channel  | handshake               | beat
//  ---------+-------------------------+------------------------------------------
//  cable in | push / full             | start, end, sag, ribbon_width, segments
//  vertex   | pop / empty             | vert_x/y/z, vert_index, degenerate, last
//  config   | cfg_valid / cfg_ready   | cfg_index (camera x, y, z), cfg_data
//
// The one shared 1-bit/cycle divider and the square root loop dominate the
// time a cable takes; the sequencer runs through both for each of its n + 1
// samples. Inactive cables are dropped by the front end and never reach the
// sequencer. Two cables can wait in front of the sequencer, two vertices
// behind it. Reset (rst, synchronous) clears the queues, the sequencer and
// the camera. A full vertex queue stalls the sequencer in place; cfg_ready
// is always high.
`default_nettype none

module cable_ribbon_tessellator #(
  parameter int MAX_SEGMENTS = crt_pkg::DEF_MAX_SEGMENTS,
  parameter int COORD_BITS   = crt_pkg::DEF_COORD_BITS
) (
  input  wire logic                          clk,
  input  wire logic                          rst,
  // cable in
  input  wire logic                          push,
  output logic                               full,
  input  wire crt_pkg::coord_t               start_x,
  input  wire crt_pkg::coord_t               start_y,
  input  wire crt_pkg::coord_t               start_z,
  input  wire crt_pkg::coord_t               end_x,
  input  wire crt_pkg::coord_t               end_y,
  input  wire crt_pkg::coord_t               end_z,
  input  wire crt_pkg::coord_t               sag,
  input  wire logic [crt_pkg::WIDTH_W-1:0]   ribbon_width,
  input  wire logic [crt_pkg::SEG_W-1:0]     segment_count,
  input  wire logic                          cable_active,
  // vertex out
  output logic                               empty,
  input  wire logic                          pop,
  output crt_pkg::coord_t                    vert_x,
  output crt_pkg::coord_t                    vert_y,
  output crt_pkg::coord_t                    vert_z,
  output logic [crt_pkg::IDX_W-1:0]          vert_index,
  output logic                               degenerate,
  output logic                               last_vertex,
  // config
  input  wire logic                          cfg_valid,
  output logic                               cfg_ready,
  input  wire logic [crt_pkg::CFG_IDX_W-1:0] cfg_index,
  input  wire crt_pkg::coord_t               cfg_data
);
  import crt_pkg::*;

  coord_t [2:0] cam;

  logic  dq_full;
  logic  dq_push;
  desc_t dq_in;
  desc_t dq_out;
  logic  dq_empty;
  logic  dq_pop;

  vert_t oq_in;
  logic  oq_push;
  logic  oq_full;
  vert_t oq_out;

  // camera registers; the sequencer reads them live, so the host writes
  // them only while no cable is in flight
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      cam <= '0;
    end else if (cfg_valid) begin
      case (cfg_index)
        CFG_CAMERA_X: cam[0] <= cfg_data;
        CFG_CAMERA_Y: cam[1] <= cfg_data;
        CFG_CAMERA_Z: cam[2] <= cfg_data;
        default: ;
      endcase
    end
  end

  crt_front #(.MAX_SEGMENTS(MAX_SEGMENTS)) u_front (
    .push          (push),
    .full          (full),
    .start_x       (start_x),
    .start_y       (start_y),
    .start_z       (start_z),
    .end_x         (end_x),
    .end_y         (end_y),
    .end_z         (end_z),
    .sag           (sag),
    .ribbon_width  (ribbon_width),
    .segment_count (segment_count),
    .cable_active  (cable_active),
    .q_full        (dq_full),
    .q_push        (dq_push),
    .q_desc        (dq_in)
  );

  // cable queue between front end and sequencer
  crt_fifo #(.WIDTH($bits(desc_t)), .DEPTH(DESC_DEPTH)) u_desc_q (
    .clk     (clk),
    .rst     (rst),
    .wr_en   (dq_push),
    .wr_data (dq_in),
    .full    (dq_full),
    .rd_en   (dq_pop),
    .rd_data (dq_out),
    .empty   (dq_empty)
  );

  crt_back #(.COORD_BITS(COORD_BITS)) u_back (
    .clk        (clk),
    .rst        (rst),
    .desc       (dq_out),
    .desc_empty (dq_empty),
    .desc_pop   (dq_pop),
    .cam        (cam),
    .out_vert   (oq_in),
    .out_push   (oq_push),
    .out_full   (oq_full)
  );

  // vertex queue; the head beat sits on the result ports
  crt_fifo #(.WIDTH($bits(vert_t)), .DEPTH(OUT_DEPTH)) u_vert_q (
    .clk     (clk),
    .rst     (rst),
    .wr_en   (oq_push),
    .wr_data (oq_in),
    .full    (oq_full),
    .rd_en   (pop),
    .rd_data (oq_out),
    .empty   (empty)
  );

  assign vert_x      = oq_out.x;
  assign vert_y      = oq_out.y;
  assign vert_z      = oq_out.z;
  assign vert_index  = oq_out.index;
  assign degenerate  = oq_out.degenerate;
  assign last_vertex = oq_out.last;

endmodule

`default_nettype wire

// File: tb/tb_cable_ribbon_tessellator.sv
// tb_cable_ribbon_tessellator: self-checking testbench for the cable ribbon
// tessellator. Predicts every strip vertex from the cable and camera, compares.
// Depends on crt_pkg and cable_ribbon_tessellator.
`timescale 1ns / 1ps

module tb_cable_ribbon_tessellator;
  import crt_pkg::*;

  typedef struct packed {
    coord_t           x;
    coord_t           y;
    coord_t           z;
    logic [IDX_W-1:0] index;
    logic             degen;
    logic             last;
  } strip_vert_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic push = 1'b0;
  logic full;
  coord_t start_x = '0, start_y = '0, start_z = '0;
  coord_t end_x = '0, end_y = '0, end_z = '0, sag = '0;
  logic [WIDTH_W-1:0] ribbon_width = '0;
  logic [SEG_W-1:0] segment_count = '0;
  logic cable_active = 1'b0;
  logic empty;
  logic pop = 1'b0;
  coord_t vert_x, vert_y, vert_z;
  logic [IDX_W-1:0] vert_index;
  logic degenerate, last_vertex;
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  coord_t cfg_data = '0;

  cable_ribbon_tessellator i_dut (.*);

  initial begin
    forever #4 clk = ~clk;
  end

  // camera copy used for prediction
  longint cam_pos [3];
  strip_vert_t pending_verts [$];
  int errors = 0;
  int send_gap_pct = 0;  // sender idle chance, percent
  int recv_gap_pct = 0;  // receiver stall chance, percent

  // ---------------------------------------------------------------- predictor

  function automatic longint div_floor(longint a, longint b);
    longint q;
    q = a / b;
    if ((a % b) != 0 && a < 0) q--;
    return q;
  endfunction

  function automatic longint unsigned sqrt_floor(longint unsigned v);
    longint unsigned r, b;
    r = 0;
    b = 64'd1 << 62;
    while (b > v) b >>= 2;
    while (b != 0) begin
      if (v >= r + b) begin
        v -= r + b;
        r = (r >> 1) + b;
      end else begin
        r >>= 1;
      end
      b >>= 2;
    end
    return r;
  endfunction

  // Q16.16 unit vector; returns 0 for a zero-length input
  function automatic bit to_unit(input longint v [3], output longint u [3]);
    longint unsigned mag [3];
    longint unsigned mx, sum, len, q;
    mx = 0;
    sum = 0;
    for (int k = 0; k < 3; k++) begin
      mag[k] = v[k] < 0 ? -v[k] : v[k];
      if (mag[k] > mx) mx = mag[k];
    end
    if (mx == 0) begin
      u = '{0, 0, 0};
      return 0;
    end
    while (mx >= (64'd1 << 30)) begin
      for (int k = 0; k < 3; k++) mag[k] >>= 1;
      mx >>= 1;
    end
    while (mx < (64'd1 << 29)) begin
      for (int k = 0; k < 3; k++) mag[k] <<= 1;
      mx <<= 1;
    end
    for (int k = 0; k < 3; k++) sum += mag[k] * mag[k];
    len = sqrt_floor(sum);
    for (int k = 0; k < 3; k++) begin
      q = (mag[k] * 65536 + len / 2) / len;
      u[k] = v[k] < 0 ? -longint'(q) : longint'(q);
    end
    return 1;
  endfunction

  function automatic void bezier_at(longint s [3], longint m [3], longint e [3],
                                    longint i, longint n, output longint p [3]);
    longint d, num;
    d = n * n;
    for (int k = 0; k < 3; k++) begin
      num = s[k] * (n - i) * (n - i) + 2 * m[k] * i * (n - i) + e[k] * i * i;
      p[k] = div_floor(num + d / 2, d);
    end
  endfunction

  function automatic coord_t saturate_coord(longint v);
    if (v > 64'sd2147483647) v = 64'sd2147483647;
    if (v < -64'sd2147483648) v = -64'sd2147483648;
    return coord_t'(v);
  endfunction

  // queue up the strip a cable should produce
  function automatic void predict_strip(coord_t sp [3], coord_t ep [3], coord_t sg,
                                        logic [WIDTH_W-1:0] w, logic [SEG_W-1:0] segs);
    longint s [3], m [3], e [3], p [3], nb [3], dir [3], vw [3];
    longint ud [3], uv [3], cr [3], uc [3], side [3];
    longint n;
    bit ok;
    strip_vert_t v;
    for (int k = 0; k < 3; k++) begin
      s[k] = sp[k];
      e[k] = ep[k];
      m[k] = div_floor(s[k] + e[k], 2);
    end
    m[1] -= longint'(sg);
    n = segs;
    if (n < 1) n = 1;
    for (longint i = 0; i <= n; i++) begin
      bezier_at(s, m, e, i, n, p);
      bezier_at(s, m, e, i < n ? i + 1 : i - 1, n, nb);
      for (int k = 0; k < 3; k++) begin
        dir[k] = i < n ? nb[k] - p[k] : p[k] - nb[k];
        vw[k] = cam_pos[k] - p[k];
      end
      ok = to_unit(dir, ud);
      ok = to_unit(vw, uv) && ok;
      cr[0] = ud[1] * uv[2] - ud[2] * uv[1];
      cr[1] = ud[2] * uv[0] - ud[0] * uv[2];
      cr[2] = ud[0] * uv[1] - ud[1] * uv[0];
      ok = to_unit(cr, uc) && ok;
      for (int k = 0; k < 3; k++) side[k] = div_floor(uc[k] * longint'(w) + 65536, 131072);
      for (int sd = 0; sd < 2; sd++) begin
        v.x = saturate_coord(sd == 0 ? p[0] - side[0] : p[0] + side[0]);
        v.y = saturate_coord(sd == 0 ? p[1] - side[1] : p[1] + side[1]);
        v.z = saturate_coord(sd == 0 ? p[2] - side[2] : p[2] + side[2]);
        v.index = IDX_W'(2 * i + sd);
        v.degen = !ok;
        v.last = (i == n && sd == 1);
        pending_verts.insert(pending_verts.size(), v);
      end
    end
  endfunction

  // ----------------------------------------------------------------- drivers

  task automatic write_camera(logic [CFG_IDX_W-1:0] idx, coord_t val);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    do @(posedge clk); while (!cfg_ready);
    cam_pos[idx] = val;
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  task automatic set_camera(coord_t x, coord_t y, coord_t z);
    write_camera(CFG_CAMERA_X, x);
    write_camera(CFG_CAMERA_Y, y);
    write_camera(CFG_CAMERA_Z, z);
  endtask

  // one cable beat; push stays high across back-to-back beats
  task automatic send_cable(coord_t sx, coord_t sy, coord_t sz, coord_t ex,
                            coord_t ey, coord_t ez, coord_t sg,
                            logic [WIDTH_W-1:0] w, logic [SEG_W-1:0] segs,
                            logic act);
    coord_t sp [3], ep [3];
    while ($urandom_range(99) < send_gap_pct) begin
      push <= 1'b0;
      @(negedge clk);
    end
    push <= 1'b1;
    start_x <= sx; start_y <= sy; start_z <= sz;
    end_x <= ex; end_y <= ey; end_z <= ez;
    sag <= sg;
    ribbon_width <= w;
    segment_count <= segs;
    cable_active <= act;
    do @(posedge clk); while (full);
    sp = '{sx, sy, sz};
    ep = '{ex, ey, ez};
    if (act) predict_strip(sp, ep, sg, w, segs);
    @(negedge clk);
  endtask

  task automatic stop_push();
    push <= 1'b0;
  endtask

  // quiet point for config writes
  task automatic drain();
    stop_push();
    while (pending_verts.size() != 0) @(posedge clk);
    repeat (50) @(posedge clk);
    @(negedge clk);
  endtask

  // mostly small segment counts, sometimes the largest or zero
  function automatic logic [SEG_W-1:0] pick_segments();
    int r;
    r = $urandom_range(99);
    if (r < 4) return 5'd31;
    if (r < 8) return 5'd0;
    return SEG_W'($urandom_range(4, 1));
  endfunction

  function automatic coord_t pick_coord();
    case ($urandom_range(5))
      0: return 32'h7fffffff;
      1: return 32'h80000000;
      2: return coord_t'($urandom_range(65536 * 8) - 65536 * 4);
      default: return coord_t'($urandom);
    endcase
  endfunction

  task automatic send_random_cable();
    coord_t sx, sy, sz;
    sx = pick_coord();
    sy = pick_coord();
    sz = pick_coord();
    // a few cables with coincident ends give zero tangents
    if ($urandom_range(9) == 0)
      send_cable(sx, sy, sz, sx, sy, sz, 0, WIDTH_W'($urandom), pick_segments(), 1'b1);
    else
      send_cable(sx, sy, sz, pick_coord(), pick_coord(), pick_coord(), pick_coord(),
                 WIDTH_W'($urandom), pick_segments(), $urandom_range(9) != 0);
  endtask

  // ------------------------------------------------------------------ checker

  always @(posedge clk) begin
    strip_vert_t want;
    if (!rst && pop && !empty) begin
      if (pending_verts.size() == 0) begin
        $error("vertex with no prediction waiting, index %0d", vert_index);
        errors++;
      end else begin
        want = pending_verts.pop_front();
        if (vert_x !== want.x) begin
          $error("vert_x: expected %h, got %h", want.x, vert_x); errors++;
        end
        if (vert_y !== want.y) begin
          $error("vert_y: expected %h, got %h", want.y, vert_y); errors++;
        end
        if (vert_z !== want.z) begin
          $error("vert_z: expected %h, got %h", want.z, vert_z); errors++;
        end
        if (vert_index !== want.index) begin
          $error("vert_index: expected %0d, got %0d", want.index, vert_index); errors++;
        end
        if (degenerate !== want.degen) begin
          $error("degenerate: expected %0d, got %0d", want.degen, degenerate); errors++;
        end
        if (last_vertex !== want.last) begin
          $error("last_vertex: expected %0d, got %0d", want.last, last_vertex); errors++;
        end
      end
    end
  end

  // receiver stalls on the falling edge
  always @(negedge clk) pop <= ($urandom_range(99) >= recv_gap_pct);

  // -------------------------------------------------------------------- tests

  // extremes of every field, an inactive cable, segment count edge cases, zero vectors
  task automatic test_directed();
    send_cable(0, 0, 0, 32'h00010000, 0, 0, 0, 31'h00010000, 5'd1, 1'b1);
    send_cable(0, 0, 0, 32'h00040000, 0, 0, 32'h00010000, 31'h7fffffff, 5'd0, 1'b1);
    send_cable(32'h7fffffff, 32'h7fffffff, 32'h7fffffff, 32'h80000000, 32'h80000000,
               32'h80000000, 32'h7fffffff, 31'h7fffffff, 5'd31, 1'b1);
    send_cable(32'h80000000, 32'h80000000, 32'h80000000, 32'h7fffffff, 32'h7fffffff,
               32'h7fffffff, 32'h80000000, 31'h0, 5'd2, 1'b1);
    // inactive: nothing emitted
    send_cable('1, '1, '1, '1, '1, '1, '1, '1, '1, 1'b0);
    // coincident ends, zero sag: zero tangent
    send_cable(32'h00050000, 32'h00030000, 0, 32'h00050000, 32'h00030000, 0, 0,
               31'h00020000, 5'd3, 1'b1);
    // point on the camera: zero view vector at the start
    send_cable(0, 0, 0, 0, 0, 32'h00020000, 0, 31'h00010000, 5'd2, 1'b1);
    // tangent parallel to the view: zero cross product
    send_cable(0, 0, 32'h00010000, 0, 0, 32'h00050000, 0, 31'h00010000, 5'd1, 1'b1);
    send_cable(32'hffff0000, 32'h00010000, 32'h12345678, 32'h00020000, 32'hfffe0000,
               32'hedcba987, 32'hffff8000, 31'h55555555, 5'd16, 1'b1);
    send_cable(32'h2aaaaaaa, 32'h55555555, 32'haaaaaaaa, 32'hd5555555, 32'h0000ffff,
               32'h3, 32'h00000001, 31'h2aaaaaaa, 5'd7, 1'b1);
    drain();
  endtask

  task automatic test_random(int count);
    for (int j = 0; j < count; j++) send_random_cable();
    drain();
  endtask

  // sender waits for every prediction to clear before going on
  task automatic test_pause_until_drained();
    for (int j = 0; j < 4; j++) send_random_cable();
    stop_push();
    while (pending_verts.size() != 0) @(posedge clk);
    @(negedge clk);
    for (int j = 0; j < 4; j++) send_random_cable();
    drain();
  endtask

  initial begin
    cam_pos = '{0, 0, 0};
    repeat (5) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    test_directed();

    send_gap_pct = 9;
    recv_gap_pct = 62;
    set_camera(32'h7fffffff, 32'h80000000, 32'h7fffffff);
    test_random(80);

    send_gap_pct = 62;
    recv_gap_pct = 9;
    set_camera(32'h80000000, 32'h7fffffff, 32'h80000000);
    test_random(80);
    test_pause_until_drained();

    send_gap_pct = 0;
    recv_gap_pct = 0;
    set_camera(coord_t'($urandom), coord_t'($urandom), coord_t'($urandom));
    test_random(80);

    if (errors == 0)
      $display("No mismatches found");
    else
      $display("Mismatches found");
    $finish;
  end

  // timeout guard, sized for the slowest cables with stalls and gaps
  initial begin
    #400ms;
    $display("Mismatches found");
    $finish;
  end

endmodule
